// ===== src/pol_pkg.sv =====
// ----------------------------------------------------------------------------
// pol_pkg: shared types and constants for the positional ordered list
// Field widths, operation and status codes, controller states and the
// control bundle that drives the row of list cells.
// ----------------------------------------------------------------------------
package pol_pkg;

	localparam int POS_W   = 6;
	localparam int VAL_W   = 32;
	localparam int MODE_W  = 2;
	localparam int STAT_W  = 2;
	localparam int TOTAL_W = 5;

	localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
	localparam logic [MODE_W-1:0] MODE_DELETE = 2'd1;
	localparam logic [MODE_W-1:0] MODE_READ   = 2'd2;

	localparam logic [STAT_W-1:0] STATUS_OK      = 2'd0;
	localparam logic [STAT_W-1:0] STATUS_BAD_POS = 2'd1;
	localparam logic [STAT_W-1:0] STATUS_FULL    = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_LOAD
	} state_t;

	typedef struct packed {
		logic ins;
		logic del;
		logic take;
		logic shift;
	} cell_ctl_t;

endpackage

// ===== src/positional_ordered_list.sv =====
// ----------------------------------------------------------------------------
// positional_ordered_list: ordered list with insert, delete and read by
// 1-based position
// A row of MAX_ENTRIES cells shifts on insert and delete all at once; read
// and delete values return to cell 0 over a walk lane.
//
//   channel | direction | beat fields
//   in      | sink      | mode, position, element_value
//   out     | source    | status, read_value, entry_total
//
// One item at a time. Read or delete at position p walks the return lane
// one cell a cycle from cell p - 1 down to cell 0 before the output beat;
// every other item goes straight to the load state. The next input beat can
// be taken in the cycle after the output register loads. A stalled output
// holds the controller in its load state. Reset clears the count and control;
// entry storage is not cleared.
// ----------------------------------------------------------------------------
module positional_ordered_list #(
	parameter int MAX_ENTRIES = 16,
	parameter int DATA_WIDTH  = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [pol_pkg::MODE_W-1:0]          mode,
	input  logic [pol_pkg::POS_W-1:0]           position,
	input  logic signed [pol_pkg::VAL_W-1:0]    element_value,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [pol_pkg::STAT_W-1:0]          status,
	output logic signed [pol_pkg::VAL_W-1:0]    read_value,
	output logic [pol_pkg::TOTAL_W-1:0]         entry_total
);
	import pol_pkg::*;

	localparam int IW   = $clog2(MAX_ENTRIES);
	localparam int CW   = $clog2(MAX_ENTRIES + 1);
	localparam int CMPW = ((CW > POS_W) ? CW : POS_W) + 1;

	state_t                  state_q;
	state_t                  state_d;
	logic [CW-1:0]           count_q;
	logic [IW-1:0]           walk_q;
	logic [STAT_W-1:0]       res_status_q;
	logic                    res_rv_q;
	logic                    out_valid_q;
	logic [STAT_W-1:0]       status_q;
	logic [VAL_W-1:0]        read_value_q;
	logic [TOTAL_W-1:0]      entry_total_q;

	logic [CMPW-1:0]         pos_c;
	logic [CMPW-1:0]         cnt_c;
	logic [POS_W-1:0]        pos_m1;
	logic [IW-1:0]           target;
	logic                    pos_zero;
	logic                    ins_pos_ok;
	logic                    acc_pos_ok;
	logic                    full;
	logic                    do_ins;
	logic                    do_del;
	logic                    do_rd;
	logic [STAT_W-1:0]       st_c;
	logic                    accept;
	logic                    shift_c;
	logic                    load_out;
	logic [DATA_WIDTH-1:0]   new_value;
	logic signed [63:0]      ret_ext;
	cell_ctl_t               ctl;

	logic [DATA_WIDTH-1:0]   ent [MAX_ENTRIES];
	logic [DATA_WIDTH-1:0]   ret [MAX_ENTRIES];

	assign pos_c      = CMPW'(position);
	assign cnt_c      = CMPW'(count_q);
	assign pos_m1     = position - POS_W'(1);
	assign target     = IW'(pos_m1);
	assign pos_zero   = (position == '0);
	assign ins_pos_ok = !pos_zero && (pos_c <= cnt_c + CMPW'(1));
	assign acc_pos_ok = !pos_zero && (pos_c <= cnt_c);
	assign full       = (count_q == CW'(MAX_ENTRIES));
	assign new_value  = DATA_WIDTH'($unsigned(element_value));

	always_comb begin
		do_ins = 1'b0;
		do_del = 1'b0;
		do_rd  = 1'b0;
		st_c   = STATUS_OK;
		case (mode)
			MODE_INSERT: begin
				if (!ins_pos_ok) begin
					st_c = STATUS_BAD_POS;
				end else if (full) begin
					st_c = STATUS_FULL;
				end else begin
					do_ins = 1'b1;
				end
			end
			MODE_DELETE: begin
				if (!acc_pos_ok) begin
					st_c = STATUS_BAD_POS;
				end else begin
					do_del = 1'b1;
				end
			end
			MODE_READ: begin
				if (!acc_pos_ok) begin
					st_c = STATUS_BAD_POS;
				end else begin
					do_rd = 1'b1;
				end
			end
			default: begin
				st_c = STATUS_OK;
			end
		endcase
	end

	assign accept = in_valid && in_ready;

	// controller: next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if ((do_del || do_rd) && (target != '0)) begin
						state_d = ST_WALK;
					end else begin
						state_d = ST_LOAD;
					end
				end
			end
			ST_WALK: begin
				if (walk_q == IW'(1)) begin
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				if (load_out) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// controller: outputs
	always_comb begin
		in_ready = 1'b0;
		shift_c  = 1'b0;
		load_out = 1'b0;
		case (state_q)
			ST_IDLE: in_ready = 1'b1;
			ST_WALK: shift_c  = 1'b1;
			ST_LOAD: load_out = !out_valid_q || out_ready;
			default: in_ready = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			walk_q  <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				if (do_ins) begin
					count_q <= count_q + CW'(1);
				end else if (do_del) begin
					count_q <= count_q - CW'(1);
				end
				walk_q <= (do_del || do_rd) ? target : '0;
			end else if (shift_c) begin
				walk_q <= walk_q - IW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_status_q <= st_c;
			res_rv_q     <= do_del || do_rd;
		end
	end

	assign ctl.ins   = accept && do_ins;
	assign ctl.del   = accept && do_del;
	assign ctl.take  = accept && (do_del || do_rd);
	assign ctl.shift = shift_c;

	for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_row
		logic [DATA_WIDTH-1:0] left_entry;
		logic [DATA_WIDTH-1:0] right_entry;
		logic [DATA_WIDTH-1:0] right_ret;

		if (i == 0) begin : g_first
			assign left_entry = '0;
		end else begin : g_inner_l
			assign left_entry = ent[i-1];
		end

		if (i == MAX_ENTRIES - 1) begin : g_last
			assign right_entry = '0;
			assign right_ret   = '0;
		end else begin : g_inner_r
			assign right_entry = ent[i+1];
			assign right_ret   = ret[i+1];
		end

		pol_cell #(
			.DATA_WIDTH (DATA_WIDTH),
			.IW         (IW),
			.IDX        (i)
		) u_cell (
			.clk         (clk),
			.ctl         (ctl),
			.target      (target),
			.new_value   (new_value),
			.left_entry  (left_entry),
			.right_entry (right_entry),
			.right_ret   (right_ret),
			.entry       (ent[i]),
			.ret         (ret[i])
		);
	end

	assign ret_ext = 64'(signed'(ret[0]));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			status_q      <= res_status_q;
			read_value_q  <= res_rv_q ? ret_ext[VAL_W-1:0] : '0;
			entry_total_q <= TOTAL_W'(count_q);
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign read_value  = signed'(read_value_q);
	assign entry_total = entry_total_q;

endmodule

// ===== src/pol_cell.sv =====
// ----------------------------------------------------------------------------
// pol_cell: one entry of the ordered list
// Holds one entry; shifts in from the left on insert, from the right on
// delete, and carries a return lane that walks a picked entry towards cell 0.
// ----------------------------------------------------------------------------
module pol_cell #(
	parameter int DATA_WIDTH = 32,
	parameter int IW         = 4,
	parameter int IDX        = 0
) (
	input  logic                  clk,
	input  pol_pkg::cell_ctl_t    ctl,
	input  logic [IW-1:0]         target,
	input  logic [DATA_WIDTH-1:0] new_value,
	input  logic [DATA_WIDTH-1:0] left_entry,
	input  logic [DATA_WIDTH-1:0] right_entry,
	input  logic [DATA_WIDTH-1:0] right_ret,
	output logic [DATA_WIDTH-1:0] entry,
	output logic [DATA_WIDTH-1:0] ret
);
	import pol_pkg::*;

	logic [DATA_WIDTH-1:0] entry_q;
	logic [DATA_WIDTH-1:0] ret_q;
	logic                  hit;
	logic                  above;

	assign hit   = (target == IW'(IDX));
	assign above = (IW'(IDX) > target);

	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (above) begin
				entry_q <= left_entry;
			end else if (hit) begin
				entry_q <= new_value;
			end
		end else if (ctl.del) begin
			if (above || hit) begin
				entry_q <= right_entry;
			end
		end
	end

	// pick the addressed entry, then walk it down the lane
	always_ff @(posedge clk) begin
		if (ctl.take) begin
			ret_q <= hit ? entry_q : '0;
		end else if (ctl.shift) begin
			ret_q <= right_ret;
		end
	end

	assign entry = entry_q;
	assign ret   = ret_q;

endmodule

// ===== src/pol_checker.sv =====
// ----------------------------------------------------------------------------
// pol_checker: port-level checks for the positional ordered list
// Watches the two channels and flags protocol and result slips.
// ----------------------------------------------------------------------------
module pol_checker #(
	parameter int MAX_ENTRIES = 16
) (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_ready,
	input logic [pol_pkg::MODE_W-1:0]       mode,
	input logic [pol_pkg::POS_W-1:0]        position,
	input logic signed [pol_pkg::VAL_W-1:0] element_value,
	input logic                             out_valid,
	input logic                             out_ready,
	input logic [pol_pkg::STAT_W-1:0]       status,
	input logic signed [pol_pkg::VAL_W-1:0] read_value,
	input logic [pol_pkg::TOTAL_W-1:0]      entry_total
);
	import pol_pkg::*;

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=>
			in_valid && $stable(mode) && $stable(position) && $stable(element_value))
		else $error("input beat changed while waiting");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=>
			out_valid && $stable(status) && $stable(read_value) && $stable(entry_total))
		else $error("output beat changed while stalled");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != STATUS_OK) |-> read_value == '0)
		else $error("error beat carries a value");

	a_full_total: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == STATUS_FULL) |-> entry_total == TOTAL_W'(MAX_ENTRIES))
		else $error("full status with list not full");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input beat taken while an item is in flight");

endmodule

bind positional_ordered_list pol_checker #(
	.MAX_ENTRIES (MAX_ENTRIES)
) u_pol_checker (.*);
